// ----- sv/slcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants for the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

  // Input item kinds (s_tuser)
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result kinds (m_tuser)
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ERR  = 1'b1;

  localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd40;

  // Payload length and index fit a byte for any supported payload size
  localparam int LEN_W = 8;

  // One finished frame handed from the parser to the emitter
  typedef struct packed {
    logic             err;
    logic [7:0]       frame_type;
    logic [LEN_W-1:0] len;
    logic             bank;
  } job_t;

  // Payload buffer write from the parser
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [LEN_W-1:0] idx;
    logic [7:0]       data;
  } mem_wr_t;

endpackage

// ----- sv/sync_length_checksum_deframer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// Finds 0xFF 0xFF framed packets with a type/length header and additive
// checksum; emits payload bytes of good frames or one error result.
// ----------------------------------------------------------------------------
//  channel | ports                     | contents
//  --------+---------------------------+---------------------------------------
//  s       | s_tvalid/s_tready         | tdata: rx_byte; tuser: cmd
//  m       | m_tvalid/m_tready/m_tlast | tdata: frame_type, payload_byte,
//          |                           | byte_index, payload_len; tuser: kind;
//          |                           | tlast: last
//  cfg     | cfg_we/cfg_wdata          | timeout_ticks
//
// The parser takes one byte or tick per cycle; a checksum byte queues the
// frame, and the emitter then gives one result per cycle from the payload
// buffer; the frame passes the queue entry, then the output register.
// Input stalls only while the two-entry frame queue is full, i.e. two frames
// await emission; the emitter stalls on m_tready alone.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer #(
  parameter int MAX_PAYLOAD = 17
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] frame_type, [15:8] payload_byte,
                                 // [20:16] byte_index, [25:21] payload_len
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast
);
  import slcd_pkg::*;

  logic    push;
  job_t    push_job;
  mem_wr_t mem_wr;
  logic    q_full;
  logic    q_valid;
  job_t    q_job;
  logic    pop;

  logic [7:0] out_type;
  logic [7:0] out_payload;
  logic [4:0] out_index;
  logic [4:0] out_len;

  slcd_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (s_tuser),
    .in_byte  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job),
    .mem_wr   (mem_wr)
  );

  slcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .head_valid(q_valid),
    .head_job  (q_job)
  );

  slcd_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .mem_wr     (mem_wr),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_type   (out_type),
    .out_payload(out_payload),
    .out_index  (out_index),
    .out_len    (out_len),
    .out_last   (m_tlast)
  );

  // Result packing, lowest field first
  assign m_tdata = {6'd0, out_len, out_index, out_payload, out_type};

endmodule

// ----- sv/slcd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_front
// Byte parser: sync hunt, header, payload capture, checksum and tick timer.
// ----------------------------------------------------------------------------
module slcd_front #(
  parameter int MAX_PAYLOAD = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [7:0]        in_byte,
  input  logic              q_full,
  output logic              push,
  output slcd_pkg::job_t    push_job,
  output slcd_pkg::mem_wr_t mem_wr
);
  import slcd_pkg::*;

  localparam int LW = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC2,
    PH_HEAD,
    PH_DATA,
    PH_CSUM
  } phase_t;

  phase_t        phase;
  logic [1:0]    hcount;
  logic [7:0]    ftype;
  logic [7:0]    len_hi;
  logic [LW-1:0] flen;
  logic [LW-1:0] pcount;
  logic [7:0]    sum;
  logic [15:0]   timer;
  logic          armed;
  logic [15:0]   timeout;
  logic          bank;

  logic          take;
  logic          is_byte;
  logic [15:0]   len16;
  logic          len_ok;
  logic [15:0]   timer_next;
  logic [LW-1:0] pcount_next;

  // Handshake: hold off only while the frame queue is full
  assign in_ready = !q_full;
  assign take     = in_valid && !q_full;
  assign is_byte  = take && (in_cmd == CMD_BYTE);

  // Header length check and counters
  assign len16       = {len_hi, in_byte};
  assign len_ok      = (len16 != 16'd0) && (len16 <= 16'(MAX_PAYLOAD));
  assign timer_next  = (timer == 16'hFFFF) ? timer : timer + 16'd1;
  assign pcount_next = pcount + LW'(1);

  // Checksum byte closes the frame and hands it on
  always_comb begin
    push                = is_byte && (phase == PH_CSUM);
    push_job.err        = (sum != in_byte);
    push_job.frame_type = ftype;
    push_job.len        = LEN_W'(flen);
    push_job.bank       = bank;
    mem_wr.en           = is_byte && (phase == PH_DATA);
    mem_wr.bank         = bank;
    mem_wr.idx          = LEN_W'(pcount);
    mem_wr.data         = in_byte;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HUNT;
      hcount  <= '0;
      pcount  <= '0;
      sum     <= '0;
      timer   <= '0;
      armed   <= 1'b0;
      timeout <= TIMEOUT_RESET;
      bank    <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout <= cfg_wdata;
      end
      if (take && in_cmd == CMD_TICK) begin
        // tick: advance and maybe expire the frame timer
        if (armed) begin
          timer <= timer_next;
          if (timer_next >= timeout) begin
            armed <= 1'b0;
            phase <= PH_HUNT;
          end
        end
      end else if (take) begin
        case (phase)
          PH_SYNC2: begin
            if (in_byte == SYNC_BYTE) begin
              hcount <= '0;
              sum    <= '0;
              phase  <= PH_HEAD;
            end else begin
              phase <= PH_HUNT;
            end
          end
          PH_HEAD: begin
            sum <= sum + in_byte;
            case (hcount)
              2'd0: begin
                ftype  <= in_byte;
                hcount <= 2'd1;
              end
              2'd1: begin
                len_hi <= in_byte;
                hcount <= 2'd2;
              end
              default: begin
                hcount <= '0;
                flen   <= LW'(len16);
                pcount <= '0;
                phase  <= len_ok ? PH_DATA : PH_HUNT;
              end
            endcase
          end
          PH_DATA: begin
            sum    <= sum + in_byte;
            pcount <= pcount_next;
            if (pcount_next >= flen) begin
              phase <= PH_CSUM;
            end
          end
          PH_CSUM: begin
            armed <= 1'b0;
            timer <= '0;
            phase <= PH_HUNT;
            // a good frame keeps its buffer half until emitted
            if (sum == in_byte) begin
              bank <= !bank;
            end
          end
          default: begin
            phase <= PH_HUNT;
            if (in_byte == SYNC_BYTE) begin
              phase <= PH_SYNC2;
              timer <= '0;
              armed <= 1'b1;
            end
          end
        endcase
      end
    end
  end

endmodule

// ----- sv/slcd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_queue
// Two-entry frame queue between the parser and the emitter.
// ----------------------------------------------------------------------------
module slcd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  slcd_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output slcd_pkg::job_t head_job
);
  import slcd_pkg::*;

  job_t       ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = ent[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/slcd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_back
// Result emitter: payload buffer and one result per cycle, while out_ready
// allows, into an output register.
// ----------------------------------------------------------------------------
module slcd_back #(
  parameter int MAX_PAYLOAD = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  slcd_pkg::mem_wr_t mem_wr,
  input  logic              q_valid,
  input  slcd_pkg::job_t    q_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [7:0]        out_type,
  output logic [7:0]        out_payload,
  output logic [4:0]        out_index,
  output logic [4:0]        out_len,
  output logic              out_last
);
  import slcd_pkg::*;

  localparam int LW = $clog2(MAX_PAYLOAD + 1);
  localparam int IW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // Two halves, one per frame in flight
  logic [7:0]    mem [2**(IW+1)];
  logic [7:0]    rd_data;

  logic [LW-1:0] idx;
  logic          emit;
  logic          last_now;
  logic          kind_r;
  logic [LW-1:0] idx_r;
  logic [LW-1:0] len_r;

  assign emit     = q_valid && (!out_valid || out_ready);
  assign last_now = q_job.err || (LW'(idx + LW'(1)) == q_job.len[LW-1:0]);
  assign pop      = emit && last_now;

  // Payload buffer
  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem[{mem_wr.bank, mem_wr.idx[IW-1:0]}] <= mem_wr.data;
    end
    if (emit) begin
      rd_data <= mem[{q_job.bank, idx[IW-1:0]}];
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r   <= q_job.err ? KIND_ERR : KIND_DATA;
      out_type <= q_job.frame_type;
      idx_r    <= q_job.err ? '0 : idx;
      len_r    <= q_job.len[LW-1:0];
      out_last <= last_now;
    end
  end

  // Byte counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        idx       <= last_now ? '0 : idx + LW'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_kind    = kind_r;
  assign out_payload = (kind_r == KIND_ERR) ? 8'd0 : rd_data;
  assign out_index   = 5'(idx_r);
  assign out_len     = 5'(len_r);

endmodule

// ----- sv/slcd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_checker
// Port-level checks on the result stream of the deframer.
// ----------------------------------------------------------------------------
module slcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // Error result stands alone with no payload
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata[20:8] == 13'd0))
    else $error("error result malformed");

  // Good result is last exactly at the final index
  a_data_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tlast == (m_tdata[25:21] == 5'(m_tdata[20:16] + 5'd1))))
    else $error("last flag out of step with index");

  // A result right after a non-last good one is good and continues the same frame
  a_data_seq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tuser && !m_tlast ##1 m_tvalid |->
      !m_tuser && (m_tdata[20:16] == 5'($past(m_tdata[20:16]) + 5'd1))
      && (m_tdata[7:0] == $past(m_tdata[7:0])))
    else $error("payload run broken");

endmodule

bind sync_length_checksum_deframer slcd_checker u_slcd_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser),
  .m_tlast (m_tlast)
);
